// ===== hdl/doc_pkg.sv =====
package doc_pkg;

  localparam int NodeW    = 5;
  localparam int NodesDef = 26;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_SEQ_ITEM = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
    logic             seq_last;
  } in_item_t;

  typedef struct packed {
    logic order_wrong;
    logic is_last;
  } out_item_t;

  // adjacency store controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } adj_ctl_t;

  // reachability unit controls
  typedef struct packed {
    logic seed;
    logic pick_en;
    logic merge;
  } reach_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_EDGE_WR = 3'b010,
    ST_EXPAND  = 3'b100
  } state_e;

endpackage

// ===== hdl/doc_adj_ram.sv =====
module doc_adj_ram #(
  parameter int NODES = doc_pkg::NodesDef,
  parameter int AddrW = $clog2(NODES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  doc_pkg::adj_ctl_t ctl_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [NODES-1:0]  wr_data_i,
  output logic [NODES-1:0]  row_o
);

  logic [NODES-1:0] mem_q [NODES];
  logic [NODES-1:0] valid_q;
  logic [NODES-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // a row never written since the last clear reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/doc_reach_unit.sv =====
module doc_reach_unit #(
  parameter int NODES = doc_pkg::NodesDef,
  parameter int AddrW = $clog2(NODES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  doc_pkg::reach_ctl_t ctl_i,
  input  logic [AddrW-1:0]    seed_idx_i,
  input  logic [NODES-1:0]    row_i,
  output logic [AddrW-1:0]    pick_idx_o,
  output logic                pick_any_o,
  output logic [NODES-1:0]    reach_o
);

  logic [NODES-1:0] reach_q, reach_d;
  logic [NODES-1:0] pending_q, pending_d;
  logic [NODES-1:0] cand;
  logic [NODES-1:0] pick_mask;
  logic [NODES-1:0] seed_mask;

  // nodes still to be visited, with any newly arrived row forwarded
  assign cand = pending_q | (ctl_i.merge ? (row_i & ~reach_q) : '0);

  always_comb begin
    pick_idx_o = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_idx_o = AddrW'(i);
      end
    end
  end

  assign pick_any_o = |cand;
  assign pick_mask  = NODES'(1) << pick_idx_o;
  assign seed_mask  = NODES'(1) << seed_idx_i;

  always_comb begin
    reach_d   = reach_q;
    pending_d = cand & ~(ctl_i.pick_en ? pick_mask : '0);
    if (ctl_i.seed) begin
      reach_d   = seed_mask;
      pending_d = seed_mask;
    end else if (ctl_i.merge) begin
      reach_d = reach_q | row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q   <= '0;
      pending_q <= '0;
    end else begin
      reach_q   <= reach_d;
      pending_q <= pending_d;
    end
  end

  assign reach_o = reach_q;

endmodule

// ===== hdl/dependency_order_checker_unit.sv =====
// Dependency order checker. Holds a directed graph of NODES nodes and tests a
// proposed order: each sequence item (op 1) gets one result, order_wrong set
// if anything reachable from it appeared earlier in the sequence, or if an
// earlier item's result had it set; the result marked is_last is the verdict,
// after which the sequence restarts. An item is taken when start is high and
// busy is low. Results appear for a single cycle on res_valid_o and cannot be
// held off. An edge item with both nodes in range keeps the block busy while
// its row is written back; other edges, clear and unused ops leave it idle.
// A sequence item naming a valid node keeps busy high while the closure of
// the nodes reachable from it (itself included) is built, and its result is
// strobed in the first cycle busy is low again; an out-of-range node gets
// its result in the next cycle. The expansion is paced by the adjacency
// store's single read port: the closure visits one reached node a cycle,
// reading its row and merging it into the reached set.
module dependency_order_checker_unit #(
  parameter int NODES = doc_pkg::NodesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  doc_pkg::in_item_t  in_i,
  output logic               res_valid_o,
  output doc_pkg::out_item_t res_o
);

  localparam int AddrW = $clog2(NODES);
  localparam int IdxW  = (doc_pkg::NodeW > AddrW) ? doc_pkg::NodeW : AddrW;

  doc_pkg::state_e     state_q, state_d;
  logic [AddrW-1:0]    from_q, from_d;
  logic [AddrW-1:0]    to_q, to_d;
  logic                last_q, last_d;
  logic                inflight_q, inflight_d;
  logic [NODES-1:0]    seen_q, seen_d;
  logic                wrong_q, wrong_d;
  logic                res_valid_q, res_valid_d;
  doc_pkg::out_item_t  res_q, res_d;

  doc_pkg::adj_ctl_t   adj_ctl;
  doc_pkg::reach_ctl_t reach_ctl;
  logic [AddrW-1:0]    rd_addr;
  logic [NODES-1:0]    row;
  logic [NODES-1:0]    wr_data;
  logic [AddrW-1:0]    pick_idx;
  logic                pick_any;
  logic [NODES-1:0]    reach;

  logic                accept;
  logic                from_ok, to_ok;
  logic [IdxW-1:0]     from_ext, to_ext;
  logic [AddrW-1:0]    from_idx, to_idx;
  logic                hit, wrong_n;

  assign accept   = start && !busy;
  assign from_ok  = int'(in_i.from_node) < NODES;
  assign to_ok    = int'(in_i.to_node) < NODES;
  assign from_ext = IdxW'(in_i.from_node);
  assign to_ext   = IdxW'(in_i.to_node);
  assign from_idx = from_ext[AddrW-1:0];
  assign to_idx   = to_ext[AddrW-1:0];

  assign wr_data = row | (NODES'(1) << to_q);
  assign hit     = |(reach & seen_q);
  assign wrong_n = wrong_q | hit;

  doc_adj_ram #(
    .NODES (NODES),
    .AddrW (AddrW)
  ) u_adj_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (adj_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (from_q),
    .wr_data_i (wr_data),
    .row_o     (row)
  );

  doc_reach_unit #(
    .NODES (NODES),
    .AddrW (AddrW)
  ) u_reach (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (reach_ctl),
    .seed_idx_i (from_idx),
    .row_i      (row),
    .pick_idx_o (pick_idx),
    .pick_any_o (pick_any),
    .reach_o    (reach)
  );

  always_comb begin
    state_d     = state_q;
    from_d      = from_q;
    to_d        = to_q;
    last_d      = last_q;
    inflight_d  = 1'b0;
    seen_d      = seen_q;
    wrong_d     = wrong_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    adj_ctl     = '0;
    reach_ctl   = '0;
    rd_addr     = pick_idx;
    case (state_q)
      doc_pkg::ST_IDLE: begin
        if (accept) begin
          from_d = from_idx;
          to_d   = to_idx;
          last_d = in_i.seq_last;
          case (in_i.op)
            doc_pkg::OP_ADD_EDGE: begin
              if (from_ok && to_ok) begin
                adj_ctl.rd_en = 1'b1;
                rd_addr       = from_idx;
                state_d       = doc_pkg::ST_EDGE_WR;
              end
            end
            doc_pkg::OP_SEQ_ITEM: begin
              if (from_ok) begin
                reach_ctl.seed = 1'b1;
                state_d        = doc_pkg::ST_EXPAND;
              end else begin
                // node outside the graph reaches nothing
                res_valid_d       = 1'b1;
                res_d.order_wrong = wrong_q;
                res_d.is_last     = in_i.seq_last;
                if (in_i.seq_last) begin
                  seen_d  = '0;
                  wrong_d = 1'b0;
                end
              end
            end
            doc_pkg::OP_CLEAR: begin
              adj_ctl.clr = 1'b1;
              seen_d      = '0;
              wrong_d     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      doc_pkg::ST_EDGE_WR: begin
        adj_ctl.wr_en = 1'b1;
        state_d       = doc_pkg::ST_IDLE;
      end
      doc_pkg::ST_EXPAND: begin
        reach_ctl.merge = inflight_q;
        if (pick_any) begin
          reach_ctl.pick_en = 1'b1;
          adj_ctl.rd_en     = 1'b1;
          inflight_d        = 1'b1;
        end else if (!inflight_q) begin
          // closure complete
          res_valid_d       = 1'b1;
          res_d.order_wrong = wrong_n;
          res_d.is_last     = last_q;
          state_d           = doc_pkg::ST_IDLE;
          if (last_q) begin
            seen_d  = '0;
            wrong_d = 1'b0;
          end else begin
            seen_d  = seen_q | (NODES'(1) << from_q);
            wrong_d = wrong_n;
          end
        end
      end
      default: begin
        state_d = doc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= doc_pkg::ST_IDLE;
      inflight_q  <= 1'b0;
      seen_q      <= '0;
      wrong_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inflight_q  <= inflight_d;
      seen_q      <= seen_d;
      wrong_q     <= wrong_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q <= from_d;
    to_q   <= to_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != doc_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_seed_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == doc_pkg::ST_EXPAND) |-> reach[from_q])
    else $error("seed node missing from reached set");

  a_seq_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.op == doc_pkg::OP_SEQ_ITEM) && from_ok) |=> busy)
    else $error("valid sequence item did not start expansion");

  a_verdict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.is_last) |-> ((seen_q == '0) && !wrong_q))
    else $error("sequence state not cleared after verdict");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobed while still busy");

endmodule
